// ===== hw/rtl/serial_line_command_receiver_core_defines.svh =====
// assertion macros for the serial line command receiver checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef SERIAL_LINE_COMMAND_RECEIVER_CORE_DEFINES_SVH
`define SERIAL_LINE_COMMAND_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SLCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SLCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/slcr_pkg.sv =====
// shared types, codes and prefix tables of the serial line command receiver
// no dependencies
`timescale 1ns / 1ps

package slcr_pkg;

  // default line capacity; a line stores at most LINE_CAPACITY - 1 bytes, terminator included
  localparam int unsigned LineCapacityDefault = 64;

  // fixed field widths
  localparam int unsigned LineLenW = 6;
  localparam int unsigned IdleW    = 16;

  // reset value of the idle limit register
  localparam logic [IdleW-1:0] IdleLimitReset = 16'd100;

  // control characters
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  // prefix lengths
  localparam int unsigned VerLen   = 4;
  localparam int unsigned WriteLen = 8;
  localparam int unsigned ReadLen  = 7;

  // hit bit positions
  localparam int unsigned HitVer   = 0;
  localparam int unsigned HitWrite = 1;
  localparam int unsigned HitRead  = 2;

  // input item operations
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_TAKE = 2'd2
  } op_e;

  // command codes reported on a take
  typedef enum logic [2:0] {
    RES_NONE    = 3'd0,
    RES_VERSION = 3'd1,
    RES_WRITE   = 3'd2,
    RES_READ    = 3'd3,
    RES_UNKNOWN = 3'd4
  } result_e;

  // "ver\n"
  function automatic logic [7:0] ver_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h76;
      2'd1:    c = 8'h65;
      2'd2:    c = 8'h72;
      default: c = CharLf;
    endcase
    return c;
  endfunction

  // "write 1="
  function automatic logic [7:0] write_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h77;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h65;
      3'd5:    c = 8'h20;
      3'd6:    c = 8'h31;
      default: c = 8'h3D;
    endcase
    return c;
  endfunction

  // "read 1=" (position 7 is beyond the prefix and never compared)
  function automatic logic [7:0] read_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h72;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h64;
      3'd4:    c = 8'h20;
      3'd5:    c = 8'h31;
      default: c = 8'h3D;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/serial_line_command_receiver_core.sv =====
// serial line command receiver: line assembly, prefix match, idle timeout
// depends on slcr_pkg
`timescale 1ns / 1ps

//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------
//  in       | input     | in_valid_i/in_ready_o  | cmd_i, rx_byte_i, tick_amount_i
//  out      | output    | out_valid_o/out_ready_i| line_ready_o, command_o,
//           |           |                        | line_length_o, byte_accepted_o,
//           |           |                        | timed_out_o
//  cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_data_i (idle limit)
//
// one item per cycle while the output is not stalled; an accepted item passes
// the input register, then one pass of line state logic into the result register
// the input stage refills in the same cycle the result register is drained
// cfg is always ready; reset clears line state, sets the idle limit to 100
// a stalled output holds both stages; no clearing pass after reset

module serial_line_command_receiver_core
  import slcr_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY = LineCapacityDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [7:0]          tick_amount_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                line_ready_o,
  output logic [2:0]          command_o,
  output logic [LineLenW-1:0] line_length_o,
  output logic                byte_accepted_o,
  output logic                timed_out_o,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IdleW-1:0]    cfg_data_i
);

  localparam int unsigned FillW = $clog2(LINE_CAPACITY);
  localparam int unsigned LenW  = (FillW > LineLenW) ? FillW : LineLenW;
  localparam logic [FillW-1:0] LastFill = FillW'(LINE_CAPACITY - 1);

  // pipeline control
  logic s1_valid_q;
  logic advance;
  logic s1_load;

  // input register
  logic [1:0] cmd_q;
  logic [7:0] rx_byte_q;
  logic [7:0] tick_q;

  // line state
  logic [FillW-1:0] fill_q, fill_d;
  logic             fin_q, fin_d;
  logic [FillW-1:0] flen_q, flen_d;
  logic [IdleW-1:0] idle_q, idle_d;
  logic [2:0]       hits_q, hits_d;
  logic [IdleW-1:0] idle_limit_q;

  // result of the current pass
  result_e          res_cmd;
  logic             res_acc;
  logic             res_tmo;
  logic             took;
  logic [FillW-1:0] took_len;
  logic [FillW-1:0] fill_inc;
  logic [IdleW-1:0] idle_sum;
  logic [2:0]       hits_base;
  logic [LenW-1:0]  len_full;

  // result register
  logic                out_valid_q;
  logic                line_ready_q;
  logic [2:0]          command_q;
  logic [LineLenW-1:0] line_length_q;
  logic                byte_accepted_q;
  logic                timed_out_q;

  // handshake
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign s1_load     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      cmd_q     <= cmd_i;
      rx_byte_q <= rx_byte_i;
      tick_q    <= tick_amount_i;
    end
  end

  // line state update for one item
  always_comb begin
    fill_d    = fill_q;
    fin_d     = fin_q;
    flen_d    = flen_q;
    idle_d    = idle_q;
    hits_d    = hits_q;
    res_cmd   = RES_NONE;
    res_acc   = 1'b0;
    res_tmo   = 1'b0;
    took      = 1'b0;
    took_len  = flen_q;
    fill_inc  = fill_q + FillW'(1);
    idle_sum  = idle_q + IdleW'(tick_q);
    hits_base = (fill_q == '0) ? 3'b111 : hits_q;

    case (op_e'(cmd_q))
      OP_BYTE: begin
        if (!fin_q && rx_byte_q != CharCr) begin
          // clear hit bits of prefixes that mismatch at this position
          hits_d = hits_base;
          if (fill_q < FillW'(VerLen) && rx_byte_q != ver_char(fill_q[1:0])) begin
            hits_d[HitVer] = 1'b0;
          end
          if (fill_q < FillW'(WriteLen) && rx_byte_q != write_char(fill_q[2:0])) begin
            hits_d[HitWrite] = 1'b0;
          end
          if (fill_q < FillW'(ReadLen) && rx_byte_q != read_char(fill_q[2:0])) begin
            hits_d[HitRead] = 1'b0;
          end
          res_acc = 1'b1;
          fill_d  = fill_inc;
          // line ends on newline or when the fill reaches LINE_CAPACITY - 1
          if (rx_byte_q == CharLf || fill_inc == LastFill) begin
            fin_d  = 1'b1;
            flen_d = fill_inc;
            fill_d = '0;
          end
        end
      end
      OP_TICK: begin
        if (fill_q == '0) begin
          idle_d = '0;
        end else if (idle_sum > idle_limit_q) begin
          idle_d  = '0;
          fill_d  = '0;
          res_tmo = 1'b1;
        end else begin
          idle_d = idle_sum;
        end
      end
      OP_TAKE: begin
        if (fin_q) begin
          // prefix priority: ver, write, read
          if (hits_q[HitVer]) begin
            res_cmd = RES_VERSION;
          end else if (hits_q[HitWrite]) begin
            res_cmd = RES_WRITE;
          end else if (hits_q[HitRead]) begin
            res_cmd = RES_READ;
          end else begin
            res_cmd = RES_UNKNOWN;
          end
          took   = 1'b1;
          fin_d  = 1'b0;
          fill_d = '0;
        end
      end
      default: begin
      end
    endcase

    // reported length
    if (took) begin
      len_full = LenW'(took_len);
    end else if (fin_d) begin
      len_full = LenW'(flen_d);
    end else begin
      len_full = LenW'(fill_d);
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      fin_q  <= 1'b0;
      flen_q <= '0;
      idle_q <= '0;
      hits_q <= 3'b111;
    end else if (s1_valid_q && advance) begin
      fill_q <= fill_d;
      fin_q  <= fin_d;
      flen_q <= flen_d;
      idle_q <= idle_d;
      hits_q <= hits_d;
    end
  end

  // idle limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= IdleLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      idle_limit_q <= cfg_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      line_ready_q    <= fin_d;
      command_q       <= res_cmd;
      line_length_q   <= len_full[LineLenW-1:0];
      byte_accepted_q <= res_acc;
      timed_out_q     <= res_tmo;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_ready_o    = line_ready_q;
  assign command_o       = command_q;
  assign line_length_o   = line_length_q;
  assign byte_accepted_o = byte_accepted_q;
  assign timed_out_o     = timed_out_q;

endmodule

// ===== hw/rtl/slcr_checker.sv =====
// port-level checks for the serial line command receiver, bound to the top level
// depends on slcr_pkg and serial_line_command_receiver_core_defines.svh
`timescale 1ns / 1ps
`include "serial_line_command_receiver_core_defines.svh"

module slcr_checker
  import slcr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                line_ready_o,
  input logic [2:0]          command_o,
  input logic [LineLenW-1:0] line_length_o,
  input logic                byte_accepted_o,
  input logic                timed_out_o
);

  // a stalled result item holds its payload
  `SLCR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(command_o) && $stable(line_length_o), "result changed while stalled")

  // a take releases the line, so nothing is left waiting
  `SLCR_ASSERT_NOW(a_take_releases, out_valid_o && command_o != RES_NONE,
    !line_ready_o, "line still waiting after a take")

  // a stored byte item carries no command and no timeout
  `SLCR_ASSERT_NOW(a_byte_only, out_valid_o && byte_accepted_o,
    command_o == RES_NONE && !timed_out_o, "byte item reports other events")

  // a timeout empties the partial line and never coexists with a finished line
  `SLCR_ASSERT_NOW(a_timeout_empty, out_valid_o && timed_out_o,
    line_length_o == '0 && !line_ready_o, "timeout left line content")

endmodule

bind serial_line_command_receiver_core slcr_checker u_slcr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .line_ready_o    (line_ready_o),
  .command_o       (command_o),
  .line_length_o   (line_length_o),
  .byte_accepted_o (byte_accepted_o),
  .timed_out_o     (timed_out_o)
);
